// File: rtl/fch_pkg.sv
// Package for the fan curve block: field widths, register indexes,
// reset values and the configuration bundle. No dependencies.
`default_nettype none
package fch_pkg;

    localparam int TEMP_W     = 16;
    localparam int SPEED_W    = 8;
    localparam int HYST_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SEG_TOTAL  = 8;
    localparam int SEG_SEL_W  = 3;
    localparam int HSUM_W     = TEMP_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_FAN_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS_LO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLDS_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SPEEDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INVALID_FLOOR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd7;

    localparam logic [SPEED_W-1:0]       RESET_SPEED     = 8'd30;
    localparam logic signed [TEMP_W-1:0] RESET_FLOOR     = -16'sd40;
    localparam logic [SPEED_W-1:0]       RESET_MAX_SPEED = 8'd100;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [SPEED_W-1:0]       speed_t;

    typedef struct packed {
        logic                  fan_enable;
        logic [COUNT_W-1:0]    segment_count;
        logic [CFG_W-1:0]      thresholds_lo;
        logic [CFG_W-1:0]      thresholds_hi;
        logic [CFG_W-1:0]      segment_speeds;
        logic [HYST_W-1:0]     hysteresis;
        temp_t                 invalid_floor;
        speed_t                max_speed;
    } fch_cfg_t;

endpackage
`default_nettype wire

// File: rtl/fch_ifs.sv
// Valid/ready channel interfaces: temperature samples in, speed results out.
// Depends on fch_pkg.
`default_nettype none
interface fch_sample_if import fch_pkg::*; ();
    logic  valid;
    logic  ready;
    temp_t temperature;
    logic  auto_mode;

    modport source (output valid, output temperature, output auto_mode, input ready);
    modport sink   (input valid, input temperature, input auto_mode, output ready);
endinterface

interface fch_speed_if import fch_pkg::*; ();
    logic   valid;
    logic   ready;
    speed_t speed;
    logic   speed_changed;

    modport source (output valid, output speed, output speed_changed, input ready);
    modport sink   (input valid, input speed, input speed_changed, output ready);
endinterface
`default_nettype wire

// File: rtl/fch_curve.sv
// Fan curve evaluation: threshold search, invalid and unconfigured cases,
// hysteresis on speed drops. Combinational. Depends on fch_pkg.
`default_nettype none
module fch_curve import fch_pkg::*; #(
    parameter int MAX_SEGMENTS = 8
) (
    input  wire fch_cfg_t cfg,
    input  wire temp_t    temperature,
    input  wire logic     auto_mode,
    input  wire speed_t   old_speed,
    output speed_t        new_speed
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS + 1);

    logic [2*CFG_W-1:0]        thr_all;
    temp_t                     th [SEG_TOTAL];
    speed_t                    spd [SEG_TOTAL];
    logic [IDX_W-1:0]          n_eff;
    logic [IDX_W-1:0]          idx;
    logic [SEG_SEL_W-1:0]      sel;
    speed_t                    cand;
    temp_t                     th_at;
    logic signed [HSUM_W-1:0]  hsum;
    logic signed [HSUM_W-1:0]  th_ext;

    assign thr_all = {cfg.thresholds_hi, cfg.thresholds_lo};

    always_comb
    begin
        for (int k = 0; k < SEG_TOTAL; k++)
        begin
            th[k]  = thr_all[k*TEMP_W +: TEMP_W];
            spd[k] = cfg.segment_speeds[k*SPEED_W +: SPEED_W];
        end
    end

    always_comb
    begin
        if (cfg.segment_count > COUNT_W'(MAX_SEGMENTS))
            n_eff = IDX_W'(MAX_SEGMENTS);
        else
            n_eff = IDX_W'(cfg.segment_count);

        // first used threshold above the sample
        idx = n_eff;
        for (int k = MAX_SEGMENTS - 1; k >= 0; k--)
        begin
            if ((IDX_W'(k) < n_eff) && (temperature < th[k]))
                idx = IDX_W'(k);
        end

        sel   = SEG_SEL_W'(idx - IDX_W'(1));
        cand  = (idx == '0) ? '0 : spd[sel];
        th_at = th[SEG_SEL_W'(idx)];
        hsum  = HSUM_W'(temperature) + HSUM_W'({1'b0, cfg.hysteresis});
        th_ext = HSUM_W'(th_at);

        if (!(cfg.fan_enable && auto_mode))
            new_speed = old_speed;
        else if ((n_eff == '0) || (temperature < cfg.invalid_floor))
            new_speed = cfg.max_speed;
        else if ((cand < old_speed) && (idx < n_eff) && !(hsum < th_ext))
            new_speed = old_speed;
        else
            new_speed = cand;
    end

endmodule
`default_nettype wire

// File: rtl/fan_curve_with_hysteresis.sv
// Top level of the piecewise fan curve with hysteresis.
// Depends on fch_pkg, fch_ifs (channel interfaces) and fch_curve.
//
//   channel   dir   payload                          notes
//   sample    in    temperature[15:0] s, auto_mode   valid/ready
//   result    out   speed[7:0], speed_changed        valid/ready, registered
//   cfg_*     in    cfg_index[2:0], cfg_data[63:0]   write on cfg_we, no read-back
//
// One transfer per cycle sustained while results are taken; a sample passes
// through the input register, then curve logic into the result register.
// The speed state updates in the same edge that loads the result register.
// A stalled result holds; the input register still takes one sample meanwhile.
// Reset: speed 30, configuration to its documented defaults, both stages empty.
`default_nettype none
module fan_curve_with_hysteresis import fch_pkg::*; #(
    parameter int MAX_SEGMENTS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    fch_sample_if.sink                sample,
    fch_speed_if.source               result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    fch_cfg_t cfg_reg;
    logic     s1_valid_reg;
    temp_t    s1_temp_reg;
    logic     s1_auto_reg;
    logic     out_valid_reg;
    speed_t   out_speed_reg;
    logic     out_changed_reg;
    speed_t   cur_speed_reg;
    speed_t   speed_next;
    logic     out_free;
    logic     advance;

    assign out_free     = !out_valid_reg || result.ready;
    assign advance      = s1_valid_reg && out_free;
    assign sample.ready = !s1_valid_reg || out_free;

    assign result.valid         = out_valid_reg;
    assign result.speed         = out_speed_reg;
    assign result.speed_changed = out_changed_reg;

    fch_curve #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_curve (
        .cfg         (cfg_reg),
        .temperature (s1_temp_reg),
        .auto_mode   (s1_auto_reg),
        .old_speed   (cur_speed_reg),
        .new_speed   (speed_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fan_enable     <= 1'b1;
            cfg_reg.segment_count  <= '0;
            cfg_reg.thresholds_lo  <= '0;
            cfg_reg.thresholds_hi  <= '0;
            cfg_reg.segment_speeds <= '0;
            cfg_reg.hysteresis     <= '0;
            cfg_reg.invalid_floor  <= RESET_FLOOR;
            cfg_reg.max_speed      <= RESET_MAX_SPEED;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FAN_ENABLE:     cfg_reg.fan_enable     <= cfg_data[0];
                REG_SEGMENT_COUNT:  cfg_reg.segment_count  <= cfg_data[COUNT_W-1:0];
                REG_THRESHOLDS_LO:  cfg_reg.thresholds_lo  <= cfg_data;
                REG_THRESHOLDS_HI:  cfg_reg.thresholds_hi  <= cfg_data;
                REG_SEGMENT_SPEEDS: cfg_reg.segment_speeds <= cfg_data;
                REG_HYSTERESIS:     cfg_reg.hysteresis     <= cfg_data[HYST_W-1:0];
                REG_INVALID_FLOOR:  cfg_reg.invalid_floor  <= cfg_data[TEMP_W-1:0];
                REG_MAX_SPEED:      cfg_reg.max_speed      <= cfg_data[SPEED_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_speed_reg <= RESET_SPEED;
        end
        else
        begin
            if (sample.valid && sample.ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cur_speed_reg <= speed_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_temp_reg <= sample.temperature;
            s1_auto_reg <= sample.auto_mode;
        end
        if (advance)
        begin
            out_speed_reg   <= speed_next;
            out_changed_reg <= (speed_next != cur_speed_reg);
        end
    end

    // a shown result always matches the held speed state
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_speed_reg == cur_speed_reg))
        else $error("result speed differs from speed state");

    // a staged sample facing a free output moves into it
    a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("staged sample did not reach the result register");

    // with the fan off the speed never moves
    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_reg.fan_enable) |=> ($stable(cur_speed_reg) && !out_changed_reg))
        else $error("speed changed while fan disabled");

    // manual mode leaves the speed alone
    a_manual_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_auto_reg) |=> ($stable(cur_speed_reg) && !out_changed_reg))
        else $error("speed changed in manual mode");

endmodule
`default_nettype wire
